[src/sme_pkg.sv]
// Package for the stack machine execute block: widths, command and error codes, types.
`timescale 1ns / 1ps
package sme_pkg;
  localparam int STACK_DEPTH = 256;
  localparam int CALL_DEPTH  = 64;
  localparam int ADDR_BITS   = 16;
  localparam int IMM_BYTES   = 8;
  localparam int SP_BITS     = $clog2(STACK_DEPTH);
  localparam int RP_BITS     = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int SC_BITS     = $clog2(STACK_DEPTH + 1);
  localparam int RC_BITS     = $clog2(CALL_DEPTH + 1);

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3, CMD_MOD = 4'd4,
    CMD_PUSH = 4'd5, CMD_POP = 4'd6, CMD_DUP = 4'd7, CMD_SWAP = 4'd8,
    CMD_CALL = 4'd9, CMD_RET = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2, ERR_DIVZ = 3'd3, ERR_TARGET = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_ARITH, ST_WB2, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    AOP_MUL = 2'd0, AOP_DIV = 2'd1, AOP_MOD = 2'd2
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } arith_rsp_t;
endpackage

[src/stack_machine_execute.sv]
// Top level of the stack machine execute block.
`timescale 1ns / 1ps
// Executes one decoded stack-machine instruction per input beat and returns one
// result beat: next fetch address, top of stack, halted flag and error code.
// The operand stack (256 x 64) and return stack (64 x 16) sit in synchronous
// memories with registered reads. An item is taken in, the top two
// operand entries and the top return entry are read in the next cycle, the
// item executes and writes back, the result is staged, then moved into the
// output register. Add, sub, push, pop, dup, ret and call pass through the
// read, execute and output states; swap adds a second write-back state;
// mul, div and mod wait in an arithmetic state for the shared bit-serial
// multiply/divide unit. A new beat is taken once the last result is in the
// output register; a result waiting on the output does not block the input:
// the next item executes and waits in the staging register until the output frees.
// The top of stack is held in a register so results never need an extra read.
// Neither memory is cleared after reset; no entry is used before written.
module stack_machine_execute (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // [3:0] command, [67:4] immediate, [83:68] instr_address
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata   // [15:0] next_address, [79:16] top_value,
                                   // [80] halted, [83:81] error_code
);
  import sme_pkg::*;

  logic [63:0] ostk [STACK_DEPTH];
  logic [ADDR_BITS-1:0] rstk [CALL_DEPTH];

  state_t state_r, state_nxt;
  logic [SC_BITS-1:0] ocnt_r, ocnt_nxt;
  logic [RC_BITS-1:0] rcnt_r, rcnt_nxt;
  logic               halt_r, halt_nxt;
  logic [63:0]        top_r, top_nxt;
  logic [3:0]         cmd_r;
  logic [63:0]        imm_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [63:0]        ra_q, rb_q;      // second entry, top entry
  logic [ADDR_BITS-1:0] rr_q;
  logic [SP_BITS-1:0] ra_addr, rb_addr;
  logic [RP_BITS-1:0] rr_addr;

  logic               ow_en, rw_en;
  logic [SP_BITS-1:0] ow_addr;
  logic [63:0]        ow_data;
  logic [RP_BITS-1:0] rw_addr;
  logic [ADDR_BITS-1:0] rw_data;

  logic        ov_r, ov_nxt;
  logic [87:0] od_r, od_nxt;
  logic [87:0] res_r, res_nxt;   // staged result beat
  logic [63:0] sw_data_r, sw_data_nxt;

  arith_req_t  areq;
  arith_rsp_t  arsp;

  sme_arith u_arith (.clk(clk), .rst_n(rst_n), .req(areq), .a(ra_q), .b(rb_q), .rsp(arsp));

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // read addresses from the counts held at accept
  always_comb begin
    rb_addr = SP_BITS'(ocnt_r - SC_BITS'(1));
    ra_addr = SP_BITS'(ocnt_r - SC_BITS'(2));
    rr_addr = RP_BITS'(rcnt_r - RC_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (ow_en) ostk[ow_addr] <= ow_data;
    rb_q <= ostk[rb_addr];
    ra_q <= ostk[ra_addr];
  end

  always_ff @(posedge clk) begin
    if (rw_en) rstk[rw_addr] <= rw_data;
    rr_q <= rstk[rr_addr];
  end

  function automatic logic [87:0] pack_out(logic [ADDR_BITS-1:0] nx, logic [63:0] tv,
                                           logic h, err_t e);
    pack_out = {4'd0, e, h, tv, 16'(nx)};
  endfunction

  always_comb begin
    logic [ADDR_BITS-1:0] nx;
    err_t                 err;
    logic                 fin;
    state_nxt   = state_r;
    ocnt_nxt    = ocnt_r;
    rcnt_nxt    = rcnt_r;
    halt_nxt    = halt_r;
    top_nxt     = top_r;
    ov_nxt      = ov_r;
    od_nxt      = od_r;
    res_nxt     = res_r;
    sw_data_nxt = sw_data_r;
    ow_en = 1'b0; ow_addr = '0; ow_data = '0;
    rw_en = 1'b0; rw_addr = '0; rw_data = '0;
    areq  = '0;
    nx    = addr_r + ADDR_BITS'(1);
    err   = ERR_NONE;
    fin   = 1'b0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid && in_tready) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EXEC;
      ST_EXEC: begin
        fin = 1'b1;
        if (halt_r) begin
          nx = addr_r;
        end else begin
          unique case (cmd_r)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
              if (ocnt_r < SC_BITS'(2)) err = ERR_UNDER;
              else if ((cmd_r == CMD_DIV || cmd_r == CMD_MOD) && rb_q == 64'd0)
                err = ERR_DIVZ;
              else if (cmd_r == CMD_ADD || cmd_r == CMD_SUB) begin
                ow_en = 1'b1; ow_addr = ra_addr;
                ow_data = (cmd_r == CMD_ADD) ? ra_q + rb_q : ra_q - rb_q;
                top_nxt = ow_data;
                ocnt_nxt = ocnt_r - SC_BITS'(1);
              end else begin
                fin = 1'b0;
                areq.start = 1'b1;
                areq.op = (cmd_r == CMD_MUL) ? AOP_MUL :
                          (cmd_r == CMD_DIV) ? AOP_DIV : AOP_MOD;
                state_nxt = ST_ARITH;
              end
            end
            CMD_PUSH: begin
              if (ocnt_r >= SC_BITS'(STACK_DEPTH)) err = ERR_OVER;
              else begin
                ow_en = 1'b1; ow_addr = SP_BITS'(ocnt_r); ow_data = imm_r;
                top_nxt = imm_r; ocnt_nxt = ocnt_r + SC_BITS'(1);
                nx = addr_r + ADDR_BITS'(1 + IMM_BYTES);
              end
            end
            CMD_POP: begin
              if (ocnt_r == '0) err = ERR_UNDER;
              else begin
                ocnt_nxt = ocnt_r - SC_BITS'(1);
                top_nxt  = (ocnt_r == SC_BITS'(1)) ? 64'd0 : ra_q;
              end
            end
            CMD_DUP: begin
              if (ocnt_r == '0) err = ERR_UNDER;
              else if (ocnt_r >= SC_BITS'(STACK_DEPTH)) err = ERR_OVER;
              else begin
                ow_en = 1'b1; ow_addr = SP_BITS'(ocnt_r); ow_data = rb_q;
                ocnt_nxt = ocnt_r + SC_BITS'(1);
              end
            end
            CMD_SWAP: begin
              if (ocnt_r < SC_BITS'(2)) err = ERR_UNDER;
              else begin
                fin = 1'b0;
                ow_en = 1'b1; ow_addr = rb_addr; ow_data = ra_q;
                sw_data_nxt = rb_q; top_nxt = ra_q;
                state_nxt = ST_WB2;
              end
            end
            CMD_CALL: begin
              if (imm_r > 64'((65'd1 << ADDR_BITS) - 65'd1)) err = ERR_TARGET;
              else if (rcnt_r >= RC_BITS'(CALL_DEPTH)) err = ERR_OVER;
              else begin
                rw_en = 1'b1; rw_addr = RP_BITS'(rcnt_r);
                rw_data = addr_r + ADDR_BITS'(1 + IMM_BYTES);
                rcnt_nxt = rcnt_r + RC_BITS'(1);
                nx = imm_r[ADDR_BITS-1:0];
              end
            end
            CMD_RET: begin
              if (rcnt_r == '0) begin
                if (ocnt_r == '0) err = ERR_UNDER;
                else begin halt_nxt = 1'b1; nx = addr_r; end
              end else begin
                rcnt_nxt = rcnt_r - RC_BITS'(1);
                nx = rr_q;
              end
            end
            default: ;
          endcase
          if (err != ERR_NONE) begin
            halt_nxt = 1'b1; nx = addr_r;
            ocnt_nxt = ocnt_r; rcnt_nxt = rcnt_r; top_nxt = top_r;
            ow_en = 1'b0; rw_en = 1'b0;
          end
        end
      end
      ST_ARITH: begin
        if (arsp.done) begin
          ow_en = 1'b1; ow_addr = ra_addr; ow_data = arsp.res;
          top_nxt = arsp.res; ocnt_nxt = ocnt_r - SC_BITS'(1);
          fin = 1'b1;
        end
      end
      ST_WB2: begin
        ow_en = 1'b1; ow_addr = ra_addr; ow_data = sw_data_r;
        fin = 1'b1;
      end
      ST_OUT: begin
        // staged beat moves out once the output register is free
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; od_nxt = res_r; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (fin) begin
      state_nxt = ST_OUT;
      res_nxt = pack_out(nx, top_nxt, halt_nxt, err);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ocnt_r  <= '0;
      rcnt_r  <= '0;
      halt_r  <= 1'b0;
      top_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ocnt_r  <= ocnt_nxt;
      rcnt_r  <= rcnt_nxt;
      halt_r  <= halt_nxt;
      top_r   <= top_nxt;
      ov_r    <= ov_nxt;
    end
    od_r      <= od_nxt;
    res_r     <= res_nxt;
    sw_data_r <= sw_data_nxt;
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tdata[3:0];
      imm_r  <= in_tdata[67:4];
      addr_r <= in_tdata[68 +: ADDR_BITS];
    end
  end
endmodule

[src/sme_arith.sv]
// Shared multi-cycle unit: shift-add multiply and restoring divide, one bit a cycle.
`timescale 1ns / 1ps
module sme_arith (
  input  logic               clk,
  input  logic               rst_n,
  input  sme_pkg::arith_req_t req,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  output sme_pkg::arith_rsp_t rsp
);
  import sme_pkg::*;

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  arith_op_t   op_r, op_nxt;
  logic [63:0] acc_r, acc_nxt;   // product or remainder
  logic [63:0] q_r, q_nxt;       // multiplier shift or quotient
  logic [63:0] d_r, d_nxt;       // multiplicand or divisor
  logic [64:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    trial    = {acc_r, q_r[63]} - {1'b0, d_r};
    rsp.done = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      op_nxt   = req.op;
      acc_nxt  = '0;
      q_nxt    = (req.op == AOP_MUL) ? b : a;
      d_nxt    = (req.op == AOP_MUL) ? a : b;
    end else if (busy_r) begin
      if (op_r == AOP_MUL) begin
        if (q_r[0]) acc_nxt = acc_r + d_r;
        q_nxt = {1'b0, q_r[63:1]};
        d_nxt = {d_r[62:0], 1'b0};
      end else begin
        if (!trial[64]) begin
          acc_nxt = trial[63:0];
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[62:0], q_r[63]};
          q_nxt   = {q_r[62:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd64) begin
        busy_nxt = 1'b0;
        rsp.done = 1'b1;
        acc_nxt  = acc_r;
        q_nxt    = q_r;
        d_nxt    = d_r;
      end
    end
    unique case (op_r)
      AOP_MUL: rsp.res = acc_r;
      AOP_DIV: rsp.res = q_r;
      default: rsp.res = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= AOP_MUL;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end
endmodule

[src/sme_checker.sv]
// Port-level checker for the stack machine execute block, bound to the top level.
`timescale 1ns / 1ps
module sme_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);
  import sme_pkg::*;

  // a held result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");
  // a result beat stays offered until taken
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before taken");
  // an accepted beat occupies the block for the next cycle
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");
  // an error always comes with halted
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[83:81] != ERR_NONE |-> out_tdata[80])
    else $error("error without halt");
  // error codes stay in range
  a_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[83:81] <= ERR_TARGET)
    else $error("bad error code");
endmodule

bind stack_machine_execute sme_checker u_sme_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
